// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define CSV_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("csv checker: assertion failed");

// Concurrent assertion on the usual clk_i / rst_ni pair.
`define CSV_ASSERT(lbl, prop) \
  `CSV_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ===== sv/csvbfs_pkg.sv =====
// Package: byte codes, parser mode codes and shared types of the CSV splitter.
package csvbfs_pkg;

  // Byte codes with a fixed meaning
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_QUOTE   = 8'd34;
  localparam logic [7:0] CH_CR      = 8'd13;

  // Default field separator (comma)
  localparam logic [7:0] SEP_RESET  = 8'd44;

  // Parser mode codes
  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_QUOTED = 2'd1;
  localparam logic [1:0] MODE_QSEEN  = 2'd2;

  // Parser state carried from byte to byte
  typedef struct packed {
    logic [1:0] mode;
    logic       at_start;
    logic       line_open;
    logic       cr_pending;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    mode:       MODE_PLAIN,
    at_start:   1'b1,
    line_open:  1'b0,
    cr_pending: 1'b0
  };

  // One result item
  typedef struct packed {
    logic       emit_held_cr;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       field_end;
    logic       line_end;
  } parse_result_t;

endpackage

// ===== sv/csvbfs_parse.sv =====
// Combinational parse step: one byte plus current state gives result and next state.
module csvbfs_parse (
  input  logic [7:0]                in_byte_i,
  input  logic                      is_last_i,
  input  logic [7:0]                field_sep_i,
  input  csvbfs_pkg::parse_state_t  state_i,
  output csvbfs_pkg::parse_state_t  state_o,
  output csvbfs_pkg::parse_result_t result_o
);
  import csvbfs_pkg::*;

  always_comb begin
    parse_state_t  nxt;
    parse_result_t res;
    logic          content;
    logic          sep_end;

    nxt     = state_i;
    res     = '0;
    content = 1'b0;
    sep_end = 1'b0;

    if (in_byte_i == CH_NEWLINE) begin
      // newline closes the line; empty lines give no line end
      res.line_end = state_i.line_open;
      nxt          = STATE_RESET;
    end else begin
      nxt.line_open = 1'b1;

      // classify the byte by mode
      case (state_i.mode)
        MODE_QUOTED: begin
          if (in_byte_i == CH_QUOTE) nxt.mode = MODE_QSEEN;
          else                       content  = 1'b1;
        end
        MODE_QSEEN: begin
          if (in_byte_i == CH_QUOTE) begin
            nxt.mode = MODE_QUOTED;   // doubled quote
            content  = 1'b1;
          end else begin
            nxt.mode = MODE_PLAIN;
            if (in_byte_i == field_sep_i) sep_end = 1'b1;
            else                          content = 1'b1;
          end
        end
        default: begin
          nxt.mode = MODE_PLAIN;
          if (state_i.at_start && in_byte_i == CH_QUOTE) begin
            nxt.mode     = MODE_QUOTED;
            nxt.at_start = 1'b0;
          end else if (in_byte_i == field_sep_i) begin
            sep_end = 1'b1;
          end else begin
            content = 1'b1;
          end
        end
      endcase

      // separator: flush a held CR, then end the field
      if (sep_end) begin
        res.emit_held_cr = state_i.cr_pending;
        res.field_end    = 1'b1;
        nxt.cr_pending   = 1'b0;
        nxt.at_start     = 1'b1;
        nxt.mode         = MODE_PLAIN;
      end

      // content: flush a held CR, hold a new CR, else pass the byte
      if (content) begin
        nxt.at_start     = 1'b0;
        res.emit_held_cr = state_i.cr_pending;
        nxt.cr_pending   = (in_byte_i == CH_CR);
        if (in_byte_i != CH_CR) begin
          res.byte_valid = 1'b1;
          res.out_byte   = in_byte_i;
        end
      end

      // final byte ends any open line
      if (is_last_i) begin
        res.line_end = 1'b1;
        nxt          = STATE_RESET;
      end
    end

    state_o  = nxt;
    result_o = res;
  end

endmodule

// ===== sv/csv_byte_field_splitter_core.sv =====
// Top level: CSV byte stream splitter with input register and result register.
//
// Input stream (s_*): one text byte per transaction in s_tdata, s_tlast set on
// the final byte of the data. Output stream (m_*): exactly one result per
// input byte, in order. m_tdata carries the content byte (zero when none),
// m_tuser the flags, m_tlast the line end.
// Configuration: cfg_valid_i/cfg_ready_o/cfg_data_i write the field separator;
// write it only while no byte is in flight.
//
// An accepted byte is held in the input register, and its result moves into
// the output register when that register is free or being drained, so a
// receiver stall can hold it back. Throughput is one byte per cycle while the
// receiver takes each result, set by the single parse step between the
// two registers; the parser state updates as each result is registered.
// Reset clears both valid flags, resets the parser state and sets the separator to
// comma. When the receiver stalls the result stays stable, one more byte waits
// in the input register, and s_tready then drops until the result is taken.
module csv_byte_field_splitter_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,    // field_separator
  // input stream
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,       // [7:0] in_byte
  input  logic       s_tlast,       // is_last
  // output stream
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,       // [7:0] out_byte
  output logic [2:0] m_tuser,       // [0] emit_held_cr, [1] byte_valid, [2] field_end
  output logic       m_tlast        // line_end
);
  import csvbfs_pkg::*;

  logic [7:0]    sep_q;
  logic          in_valid_q;
  logic [7:0]    in_byte_q;
  logic          in_last_q;
  parse_state_t  state_q, state_d;
  parse_result_t res_d, res_q;
  logic          out_valid_q;
  logic          advance;

  // separator register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_RESET;
    end else if (cfg_valid_i) begin
      sep_q <= cfg_data_i;
    end
  end

  // move one byte into the result register when it is free or being drained
  assign advance  = in_valid_q && (!out_valid_q || m_tready);
  assign s_tready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready) begin
      in_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready && s_tvalid) begin
      in_byte_q <= s_tdata;
      in_last_q <= s_tlast;
    end
  end

  // parse step
  csvbfs_parse u_parse (
    .in_byte_i   (in_byte_q),
    .is_last_i   (in_last_q),
    .field_sep_i (sep_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .result_o    (res_d)
  );

  // parser state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_tvalid   = out_valid_q;
  assign m_tdata    = res_q.out_byte;
  assign m_tuser[0] = res_q.emit_held_cr;
  assign m_tuser[1] = res_q.byte_valid;
  assign m_tuser[2] = res_q.field_end;
  assign m_tlast    = res_q.line_end;

endmodule

// ===== sv/csvbfs_checker.sv =====
// Port-level checker for the CSV splitter, bound to the top level.
`include "assert_macros.svh"

module csvbfs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [2:0] m_tuser,
  input logic       m_tlast
);
  import csvbfs_pkg::*;

  // stalled result stays offered and unchanged
  `CSV_ASSERT(a_valid_holds, m_tvalid && !m_tready |=> m_tvalid)
  `CSV_ASSERT(a_payload_holds, m_tvalid && !m_tready |=> $stable({m_tdata, m_tuser, m_tlast}))

  // no content byte means a zero data word
  `CSV_ASSERT(a_idle_data_zero, m_tvalid && !m_tuser[1] |-> m_tdata == 8'd0)

  // newline and carriage return never come out as plain content bytes
  `CSV_ASSERT(a_no_ctrl_content, m_tvalid && m_tuser[1] |-> m_tdata != CH_NEWLINE && m_tdata != CH_CR)

endmodule

bind csv_byte_field_splitter_core csvbfs_checker u_csvbfs_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== sim/tb.sv =====
// Testbench for the CSV byte field splitter: random and directed streams vs. a predictor.
`timescale 1ns / 1ps

module tb;
  import csvbfs_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES  = 9;
  localparam logic [7:0] SEP_LIST [NUM_PHASES] = '{
    SEP_RESET, 8'h09, 8'h00, 8'hFF, 8'h3B, CH_QUOTE, CH_NEWLINE, CH_CR, SEP_RESET
  };

  // Predicts one parse result per accepted byte and checks results in order
  class parse_scoreboard;
    logic [7:0]    separator = SEP_RESET;
    logic [1:0]    mode      = MODE_PLAIN;
    bit            at_start  = 1'b1;
    bit            line_open = 1'b0;
    bit            cr_held   = 1'b0;
    parse_result_t expected_q[$];
    int            mismatches = 0;

    function void close_line();
      mode      = MODE_PLAIN;
      at_start  = 1'b1;
      line_open = 1'b0;
      cr_held   = 1'b0;
    endfunction

    // Work out the result of one accepted byte and queue it
    function void note_input(logic [7:0] b, logic last);
      parse_result_t r;
      bit content;
      bit sep_hit;
      r = '0;
      content = 1'b0;
      sep_hit = 1'b0;
      if (b == CH_NEWLINE) begin
        r.line_end = line_open;
        close_line();
      end else begin
        line_open = 1'b1;
        case (mode)
          MODE_QUOTED: begin
            if (b == CH_QUOTE) mode = MODE_QSEEN;
            else content = 1'b1;
          end
          MODE_QSEEN: begin
            if (b == CH_QUOTE) begin
              mode = MODE_QUOTED;
              content = 1'b1;
            end else begin
              mode = MODE_PLAIN;
              if (b == separator) sep_hit = 1'b1;
              else content = 1'b1;
            end
          end
          default: begin
            mode = MODE_PLAIN;
            if (at_start && b == CH_QUOTE) begin
              mode = MODE_QUOTED;
              at_start = 1'b0;
            end else if (b == separator) begin
              sep_hit = 1'b1;
            end else begin
              content = 1'b1;
            end
          end
        endcase
        // a held CR is content when the field goes on or ends at a separator
        if (sep_hit) begin
          r.emit_held_cr = cr_held;
          cr_held = 1'b0;
          r.field_end = 1'b1;
          at_start = 1'b1;
          mode = MODE_PLAIN;
        end
        if (content) begin
          at_start = 1'b0;
          r.emit_held_cr = cr_held;
          cr_held = 1'b0;
          if (b == CH_CR) begin
            cr_held = 1'b1;
          end else begin
            r.byte_valid = 1'b1;
            r.out_byte = b;
          end
        end
        if (last) begin
          r.line_end = 1'b1;
          close_line();
        end
      end
      expected_q.insert(expected_q.size(), r);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(parse_result_t got);
      parse_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with none expected: cr=%0b bv=%0b byte=%02h fe=%0b le=%0b",
                   got.emit_held_cr, got.byte_valid, got.out_byte, got.field_end,
                   got.line_end);
      end else begin
        want = expected_q.pop_front();
        if (got.emit_held_cr !== want.emit_held_cr || got.byte_valid !== want.byte_valid ||
            got.out_byte !== want.out_byte || got.field_end !== want.field_end ||
            got.line_end !== want.line_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp cr=%0b bv=%0b byte=%02h fe=%0b le=%0b,",
                     want.emit_held_cr, want.byte_valid, want.out_byte, want.field_end,
                     want.line_end,
                     " got cr=%0b bv=%0b byte=%02h fe=%0b le=%0b",
                     got.emit_held_cr, got.byte_valid, got.out_byte,
                     got.field_end, got.line_end);
        end
      end
    endfunction
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i  = 8'h00;
  logic       s_tvalid    = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata     = 8'h00;
  logic       s_tlast     = 1'b0;
  logic       m_tvalid;
  logic       m_tready    = 1'b0;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;
  logic       m_tlast;

  parse_scoreboard sb;
  bit no_idle     = 1'b0;
  int items_sent  = 0;
  int idle_cycles = 0;

  csv_byte_field_splitter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

  always #5 clk_i = ~clk_i;

  // Result side: check each transaction, stall at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready)
        sb.check_result('{emit_held_cr: m_tuser[0], byte_valid: m_tuser[1],
                          out_byte: m_tdata, field_end: m_tuser[2], line_end: m_tlast});
      m_tready <= no_idle || ($urandom_range(99) >= 24);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL csv_byte_field_splitter_core");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Send one byte, with random gaps before it
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!no_idle && $urandom_range(99) < 24) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    sb.note_input(b, last);
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit last_at_end);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], last_at_end && (i == s.len() - 1));
  endtask

  // Hold the input until every predicted result has come out
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_separator(input logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.separator = v;
  endtask

  // Field text: mostly letters, with digits, CRs, quotes, separators and random bytes
  function automatic logic [7:0] pick_text();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 8'h61 + 8'($urandom_range(25));
    if (r < 70) return 8'h30 + 8'($urandom_range(9));
    if (r < 78) return CH_CR;
    if (r < 84) return sb.separator;
    if (r < 88) return CH_QUOTE;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_field();
    int n;
    n = $urandom_range(0, 5);
    if ($urandom_range(3) == 0) begin
      // quoted field, sometimes with doubled quotes, trailing text or no close
      send_byte(CH_QUOTE, 1'b0);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(7) == 0) begin
          send_byte(CH_QUOTE, 1'b0);
          send_byte(CH_QUOTE, 1'b0);
        end else begin
          send_byte(pick_text(), 1'b0);
        end
      end
      if ($urandom_range(99) < 85) begin
        send_byte(CH_QUOTE, 1'b0);
        repeat ($urandom_range(0, 2)) send_byte(pick_text(), 1'b0);
      end
    end else begin
      for (int i = 0; i < n; i++) send_byte(pick_text(), 1'b0);
    end
  endtask

  // One line of fields and one of several endings
  task automatic send_line();
    int n_fields;
    n_fields = $urandom_range(1, 4);
    for (int f = 0; f < n_fields; f++) begin
      send_field();
      if (f != n_fields - 1) send_byte(sb.separator, 1'b0);
    end
    case ($urandom_range(9))
      0, 1, 2, 3: send_byte(CH_NEWLINE, 1'b0);
      4, 5: begin
        send_byte(CH_CR, 1'b0);
        send_byte(CH_NEWLINE, 1'b0);
      end
      6: send_byte(pick_text(), 1'b1);
      7: send_byte(sb.separator, 1'b1);
      8: send_byte(CH_CR, 1'b1);
      default: begin
        send_byte(CH_NEWLINE, 1'b0);
        send_byte(CH_NEWLINE, 1'($urandom_range(1)));
      end
    endcase
  endtask

  // Random bytes with a random final-byte flag
  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
  endtask

  initial begin
    int  mid;
    bit  paused;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty line, quoting rules, held CR cases, extremes, final bytes
    send_byte(CH_NEWLINE, 1'b0);
    send_text("a,\"x,\"\"y\"z\015,\015\015\n", 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("b\"c,\"q\n", 1'b0);
    send_text("d,", 1'b1);
    send_text("e\015", 1'b1);
    send_byte(CH_NEWLINE, 1'b1);

    // Random phases, one separator setting each
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        wait_drain();
        set_separator(SEP_LIST[p]);
      end
      no_idle = (p == 3);
      mid = items_sent + PHASE_ITEMS / 2;
      paused = 1'b0;
      while (items_sent < (p + 1) * PHASE_ITEMS) begin
        if (!paused && items_sent >= mid) begin
          wait_drain();
          paused = 1'b1;
        end
        if ($urandom_range(4) == 0) send_noise();
        else send_line();
      end
    end
    no_idle = 1'b0;

    wait_drain();
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS csv_byte_field_splitter_core");
    end else begin
      $display("FAIL csv_byte_field_splitter_core");
    end
    $finish;
  end

endmodule
